[design/bounded_doubly_linked_list_core_assert.svh]
// Assertion macros shared by the list core.
`ifndef BOUNDED_DOUBLY_LINKED_LIST_CORE_ASSERT_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define BDLL_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("list core invariant violated");

// Antecedent in one cycle implies consequent in the next.
`define BDLL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list core sequencing violated");

`endif

[design/bdll_pkg.sv]
// Package: defaults, request and status codes, and sequencer states of the list core.
package bdll_pkg;

  localparam int DEFAULT_POOL_DEPTH  = 64;
  localparam int DEFAULT_VALUE_WIDTH = 32;

  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int ITEM_W   = 32;
  localparam int COUNT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REM_VALUE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REM_MID   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ALLOC,
    S_LINK,
    S_SEARCH,
    S_WALK,
    S_UNLINK,
    S_DONE
  } state_t;

endpackage

[design/bdll_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
module bdll_ram #(
  parameter int WIDTH = bdll_pkg::DEFAULT_VALUE_WIDTH,
  parameter int DEPTH = bdll_pkg::DEFAULT_POOL_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/bounded_doubly_linked_list_core.sv]
// Bounded doubly linked list core: node pool in RAM, free stack, walk sequencer.
// Per request: insert EXEC, ALLOC, LINK, DONE; remove front/back EXEC, UNLINK, DONE; refused or
//   spare EXEC, DONE; remove by value SEARCH node by node, UNLINK on a match; remove middle WALK
//   over half the count, then UNLINK. Throughput: one transaction at a time, walks read one node
//   RAM word per link; the next request can be accepted once the result is registered.
// Reset (synchronous, rst_n low): empty list, all slots free; no RAM clearing pass.
module bounded_doubly_linked_list_core #(
  parameter int POOL_DEPTH  = bdll_pkg::DEFAULT_POOL_DEPTH,
  parameter int VALUE_WIDTH = bdll_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] removed_value, [38:32] entry_count, [39] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int IW = $clog2(POOL_DEPTH);      // slot index
  localparam int NW = $clog2(POOL_DEPTH + 1);  // link, incl. null marker
  localparam logic [NW-1:0] NIL = NW'(POOL_DEPTH);

  // Control and list head state
  bdll_pkg::state_t state_r, state_nxt;
  logic [bdll_pkg::REQ_W-1:0]    req_r, req_nxt;
  logic [VALUE_WIDTH-1:0]        v_r, v_nxt;
  logic [NW-1:0]                 len_r, len_nxt;
  logic [NW-1:0]                 first_r, first_nxt;
  logic [NW-1:0]                 last_r, last_nxt;
  logic [NW-1:0]                 free_top_r, free_top_nxt;
  // Low-water mark of the free stack: positions below it have not been written since reset
  logic [NW-1:0]                 lw_r, lw_nxt;
  logic [NW-1:0]                 cur_r, cur_nxt;
  logic [NW-1:0]                 idx_r, idx_nxt;   // search index / walk steps left
  logic [IW-1:0]                 slot_r, slot_nxt;
  logic [bdll_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [VALUE_WIDTH-1:0]        removed_r, removed_nxt;
  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [bdll_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bdll_pkg::ITEM_W-1:0]   out_removed_r, out_removed_nxt;
  logic [bdll_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  // RAM ports
  logic [IW-1:0]          node_rd_addr;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [NW-1:0]          nxt_q, prv_q;
  logic                   val_we, nxt_we, prv_we, stk_we;
  logic [IW-1:0]          val_wa, nxt_wa, prv_wa, stk_wa, stk_ra;
  logic [VALUE_WIDTH-1:0] val_wd;
  logic [NW-1:0]          nxt_wd, prv_wd;
  logic [IW-1:0]          stk_wd, stk_q;

  bdll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_DEPTH)) u_val_ram (
    .clk(clk), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
    .rd_addr(node_rd_addr), .rd_data(val_q)
  );
  bdll_ram #(.WIDTH(NW), .DEPTH(POOL_DEPTH)) u_nxt_ram (
    .clk(clk), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
    .rd_addr(node_rd_addr), .rd_data(nxt_q)
  );
  bdll_ram #(.WIDTH(NW), .DEPTH(POOL_DEPTH)) u_prv_ram (
    .clk(clk), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
    .rd_addr(node_rd_addr), .rd_data(prv_q)
  );
  bdll_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_free_ram (
    .clk(clk), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
    .rd_addr(stk_ra), .rd_data(stk_q)
  );

  // Shared conditions
  logic          in_fire, out_free, is_ins, is_rem, list_empty, pool_full;
  logic          hit, search_more, walk_more;
  logic [NW-1:0] pop_pos, half_len;
  logic [IW-1:0] alloc_slot;

  assign in_fire     = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;
  assign is_ins      = (req_r == bdll_pkg::REQ_INS_FRONT) || (req_r == bdll_pkg::REQ_INS_BACK);
  assign is_rem      = (req_r == bdll_pkg::REQ_REM_FRONT) || (req_r == bdll_pkg::REQ_REM_BACK) ||
                       (req_r == bdll_pkg::REQ_REM_VALUE) || (req_r == bdll_pkg::REQ_REM_MID);
  assign list_empty  = (len_r == '0) || (first_r >= NIL);
  assign pool_full   = (free_top_r == '0);
  assign hit         = (val_q == v_r);
  assign search_more = ((idx_r + NW'(1)) < len_r) && (nxt_q < NIL);
  assign walk_more   = (idx_r > NW'(1)) && (nxt_q < NIL);
  assign pop_pos     = free_top_r - NW'(1);
  assign half_len    = len_r >> 1;
  // Untouched stack positions hand out slots 0, 1, 2, ... in order
  assign alloc_slot  = (pop_pos < lw_r) ? (IW'(POOL_DEPTH - 1) - pop_pos[IW-1:0]) : stk_q;

  assign in_tready  = (state_r == bdll_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_count_r, out_removed_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdll_pkg::S_IDLE: begin
        if (in_fire) state_nxt = bdll_pkg::S_EXEC;
      end
      bdll_pkg::S_EXEC: begin
        if (is_ins) begin
          state_nxt = pool_full ? bdll_pkg::S_DONE : bdll_pkg::S_ALLOC;
        end else if (is_rem && !list_empty) begin
          priority case (req_r)
            bdll_pkg::REQ_REM_VALUE: state_nxt = bdll_pkg::S_SEARCH;
            bdll_pkg::REQ_REM_MID:
              state_nxt = (half_len == '0) ? bdll_pkg::S_UNLINK : bdll_pkg::S_WALK;
            default: state_nxt = bdll_pkg::S_UNLINK;
          endcase
        end else begin
          state_nxt = bdll_pkg::S_DONE;
        end
      end
      bdll_pkg::S_ALLOC: state_nxt = bdll_pkg::S_LINK;
      bdll_pkg::S_LINK:  state_nxt = bdll_pkg::S_DONE;
      bdll_pkg::S_SEARCH: begin
        if (hit)              state_nxt = bdll_pkg::S_UNLINK;
        else if (!search_more) state_nxt = bdll_pkg::S_DONE;
      end
      bdll_pkg::S_WALK: begin
        if (!walk_more) state_nxt = (nxt_q < NIL) ? bdll_pkg::S_UNLINK : bdll_pkg::S_DONE;
      end
      bdll_pkg::S_UNLINK: state_nxt = bdll_pkg::S_DONE;
      bdll_pkg::S_DONE: begin
        if (out_free) state_nxt = bdll_pkg::S_IDLE;
      end
      default: state_nxt = bdll_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    req_nxt         = req_r;
    v_nxt           = v_r;
    len_nxt         = len_r;
    first_nxt       = first_r;
    last_nxt        = last_r;
    free_top_nxt    = free_top_r;
    lw_nxt          = lw_r;
    cur_nxt         = cur_r;
    idx_nxt         = idx_r;
    slot_nxt        = slot_r;
    status_nxt      = status_r;
    removed_nxt     = removed_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_count_nxt   = out_count_r;
    node_rd_addr    = cur_r[IW-1:0];
    stk_ra          = pop_pos[IW-1:0];
    val_we = 1'b0; val_wa = slot_r; val_wd = v_r;
    nxt_we = 1'b0; nxt_wa = slot_r; nxt_wd = NIL;
    prv_we = 1'b0; prv_wa = slot_r; prv_wd = NIL;
    stk_we = 1'b0; stk_wa = free_top_r[IW-1:0]; stk_wd = cur_r[IW-1:0];

    unique case (state_r)
      bdll_pkg::S_IDLE: begin
        if (in_fire) begin
          req_nxt = in_tuser;
          v_nxt   = VALUE_WIDTH'($signed(in_tdata));
        end
      end
      bdll_pkg::S_EXEC: begin
        status_nxt  = bdll_pkg::ST_OK;
        removed_nxt = '0;
        cur_nxt     = (req_r == bdll_pkg::REQ_REM_BACK) ? last_r : first_r;
        node_rd_addr = cur_nxt[IW-1:0];
        idx_nxt     = (req_r == bdll_pkg::REQ_REM_MID) ? half_len : '0;
        if (is_ins && pool_full)        status_nxt = bdll_pkg::ST_FULL;
        else if (is_rem && list_empty)  status_nxt = bdll_pkg::ST_EMPTY;
      end
      bdll_pkg::S_ALLOC: begin
        slot_nxt     = alloc_slot;
        free_top_nxt = pop_pos;
        if (pop_pos < lw_r) lw_nxt = pop_pos;
        val_we = 1'b1; val_wa = alloc_slot;
        nxt_we = 1'b1; nxt_wa = alloc_slot;
        prv_we = 1'b1; prv_wa = alloc_slot;
        if (req_r == bdll_pkg::REQ_INS_BACK) prv_wd = last_r;
        else                                 nxt_wd = first_r;
      end
      bdll_pkg::S_LINK: begin
        len_nxt = len_r + NW'(1);
        if (req_r == bdll_pkg::REQ_INS_BACK) begin
          nxt_we = (last_r < NIL); nxt_wa = last_r[IW-1:0]; nxt_wd = NW'(slot_r);
          last_nxt = NW'(slot_r);
          if (first_r >= NIL) first_nxt = NW'(slot_r);
        end else begin
          prv_we = (first_r < NIL); prv_wa = first_r[IW-1:0]; prv_wd = NW'(slot_r);
          first_nxt = NW'(slot_r);
          if (last_r >= NIL) last_nxt = NW'(slot_r);
        end
      end
      bdll_pkg::S_SEARCH: begin
        if (!hit) begin
          idx_nxt = idx_r + NW'(1);
          if (search_more) begin
            cur_nxt      = nxt_q;
            node_rd_addr = nxt_q[IW-1:0];
          end else begin
            status_nxt = bdll_pkg::ST_NOT_FOUND;
          end
        end
      end
      bdll_pkg::S_WALK: begin
        // target may come out as the null marker: done, nothing removed
        idx_nxt      = idx_r - NW'(1);
        cur_nxt      = nxt_q;
        node_rd_addr = nxt_q[IW-1:0];
      end
      bdll_pkg::S_UNLINK: begin
        removed_nxt = val_q;
        if (prv_q < NIL) begin
          nxt_we = 1'b1; nxt_wa = prv_q[IW-1:0]; nxt_wd = nxt_q;
        end else begin
          first_nxt = nxt_q;
        end
        if (nxt_q < NIL) begin
          prv_we = 1'b1; prv_wa = nxt_q[IW-1:0]; prv_wd = prv_q;
        end else begin
          last_nxt = prv_q;
        end
        if (free_top_r < NIL) begin
          stk_we       = 1'b1;
          free_top_nxt = free_top_r + NW'(1);
        end
        if (len_r != '0) len_nxt = len_r - NW'(1);
      end
      bdll_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_removed_nxt = bdll_pkg::ITEM_W'(removed_r);
          out_count_nxt   = bdll_pkg::COUNT_W'(len_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdll_pkg::S_IDLE;
      len_r       <= '0;
      first_r     <= NIL;
      last_r      <= NIL;
      free_top_r  <= NIL;
      lw_r        <= NIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      free_top_r  <= free_top_nxt;
      lw_r        <= lw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    v_r           <= v_nxt;
    cur_r         <= cur_nxt;
    idx_r         <= idx_nxt;
    slot_r        <= slot_nxt;
    status_r      <= status_nxt;
    removed_r     <= removed_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_count_r   <= out_count_nxt;
  end

`include "bounded_doubly_linked_list_core_assert.svh"

  // slot popped in ALLOC, length grows in the following LINK state
  `BDLL_ASSERT_ALWAYS(a_count_conserved, clk, rst_n, (state_r == bdll_pkg::S_LINK) || ((len_r + free_top_r) == NIL))
  `BDLL_ASSERT_ALWAYS(a_empty_head, clk, rst_n, (len_r == '0) == (first_r == NIL))
  `BDLL_ASSERT_ALWAYS(a_low_water, clk, rst_n, lw_r <= free_top_r)
  `BDLL_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_fire, state_r == bdll_pkg::S_EXEC)
  `BDLL_ASSERT_NEXT(a_done_emits, clk, rst_n, (state_r == bdll_pkg::S_DONE) && out_free, out_valid_r && (state_r == bdll_pkg::S_IDLE))

endmodule

[tb/tb_top.sv]
// Testbench for the bounded doubly linked list core: directed and random requests, scoreboarded.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int NIL   = DEPTH;
  localparam logic [bdll_pkg::REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [bdll_pkg::REQ_W-1:0] REQ_SPARE7 = 3'd7;

  // expected outcome of one request
  typedef struct packed {
    logic [bdll_pkg::STATUS_W-1:0] status;
    logic [31:0]                   removed;
    logic [bdll_pkg::COUNT_W-1:0]  count;
  } list_reply_t;

  // Shadow deque: mirrors the pool, links and free stack of the core.
  class list_scoreboard;
    logic [31:0] vals [DEPTH];
    int          nxt [DEPTH];
    int          prv [DEPTH];
    int          free_stk [DEPTH];
    int          free_top, head, tail, length;
    list_reply_t pending[$];
    int          errors, checked;
    int          status_seen[4];

    function void clear();
      for (int i = 0; i < DEPTH; i++) free_stk[i] = DEPTH - 1 - i;
      free_top = DEPTH; head = NIL; tail = NIL; length = 0;
      errors = 0; checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void drop_node(int s);
      int p, n;
      p = prv[s]; n = nxt[s];
      if (p < NIL) nxt[p] = n; else head = n;
      if (n < NIL) prv[n] = p; else tail = p;
      free_stk[free_top++] = s;
      length--;
    endfunction

    // note an accepted request and push its expected reply
    function void note_request(logic [bdll_pkg::REQ_W-1:0] req, logic [31:0] v);
      list_reply_t r;
      int s, tgt, cur;
      r = '0; tgt = NIL;
      if (req == bdll_pkg::REQ_INS_FRONT || req == bdll_pkg::REQ_INS_BACK) begin
        if (free_top == 0) r.status = bdll_pkg::ST_FULL;
        else begin
          s = free_stk[--free_top];
          vals[s] = v;
          if (req == bdll_pkg::REQ_INS_BACK) begin
            prv[s] = tail; nxt[s] = NIL;
            if (tail < NIL) nxt[tail] = s;
            tail = s;
            if (head == NIL) head = s;
          end else begin
            nxt[s] = head; prv[s] = NIL;
            if (head < NIL) prv[head] = s;
            head = s;
            if (tail == NIL) tail = s;
          end
          length++;
        end
      end else if (req >= bdll_pkg::REQ_REM_FRONT && req <= bdll_pkg::REQ_REM_MID) begin
        if (length == 0) r.status = bdll_pkg::ST_EMPTY;
        else if (req == bdll_pkg::REQ_REM_FRONT) tgt = head;
        else if (req == bdll_pkg::REQ_REM_BACK) tgt = tail;
        else if (req == bdll_pkg::REQ_REM_VALUE) begin
          cur = head;
          while (cur < NIL) begin
            if (vals[cur] == v) begin
              tgt = cur;
              break;
            end
            cur = nxt[cur];
          end
          if (tgt == NIL) r.status = bdll_pkg::ST_NOT_FOUND;
        end else begin
          cur = head;
          for (int i = 0; i < length / 2; i++) cur = nxt[cur];
          tgt = cur;
        end
        if (r.status == bdll_pkg::ST_OK && tgt < NIL) begin
          r.removed = vals[tgt];
          drop_node(tgt);
        end
      end
      r.count = length[bdll_pkg::COUNT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_reply(logic [39:0] data, logic [1:0] user);
      list_reply_t e;
      if (pending.size() == 0) begin
        $error("reply with no request outstanding: tdata=%h tuser=%h", data, user);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      status_seen[user]++;
      if (user !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, user);
        errors++;
      end
      if (data[31:0] !== e.removed) begin
        $error("removed_value: expected %0d, actual %0d",
               $signed(e.removed), $signed(data[31:0]));
        errors++;
      end
      if (data[38:32] !== e.count) begin
        $error("entry_count: expected %0d, actual %0d", e.count, data[38:32]);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  list_scoreboard sb;
  int  cycles;
  bit  finished;
  int  stall_mode;
  // recently inserted values, so remove-by-value usually hits
  logic [31:0] recent[$];

  bounded_doubly_linked_list_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // [31:0] item_value
    .in_tuser(in_tuser),   // [2:0] req_type
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), // [31:0] removed_value, [38:32] entry_count
    .out_tuser(out_tuser)  // [1:0] status
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    sb = new();
    sb.clear();
  end

  // Capture both handshakes on the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata, out_tuser);
  end

  // Receiver back-pressure; pattern changes with stall_mode.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= (cycles % 7) < 3;
      default: out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Present one request and hold it until accepted; drops valid afterwards.
  task automatic send_request(logic [bdll_pkg::REQ_W-1:0] req, logic [31:0] v);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 1'b0;
    if (req == bdll_pkg::REQ_INS_FRONT || req == bdll_pkg::REQ_INS_BACK) begin
      recent.push_back(v);
      if (recent.size() > 16) void'(recent.pop_front());
    end
  endtask

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // Weighted operation mix; bias toward inserts or removals to sweep fill level.
  function automatic logic [bdll_pkg::REQ_W-1:0] rand_req(bit fill_bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return ($urandom_range(0, 1) != 0) ? REQ_SPARE6 : REQ_SPARE7;
    if (fill_bias) begin
      if (r < 35) return bdll_pkg::REQ_INS_FRONT;
      if (r < 70) return bdll_pkg::REQ_INS_BACK;
    end else begin
      if (r < 17) return bdll_pkg::REQ_INS_FRONT;
      if (r < 34) return bdll_pkg::REQ_INS_BACK;
    end
    case (r % 4)
      0: return bdll_pkg::REQ_REM_FRONT;
      1: return bdll_pkg::REQ_REM_BACK;
      2: return bdll_pkg::REQ_REM_VALUE;
      default: return bdll_pkg::REQ_REM_MID;
    endcase
  endfunction

  initial begin
    logic [bdll_pkg::REQ_W-1:0] req;
    logic [31:0]                v;
    int burst;
    bit fill_bias;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    rst_n = 1'b0; stall_mode = 0; finished = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty removals, extremes, duplicates, middle, spare codes.
    send_request(bdll_pkg::REQ_REM_FRONT, '0);
    send_request(bdll_pkg::REQ_REM_BACK, '0);
    send_request(bdll_pkg::REQ_REM_VALUE, 32'd5);
    send_request(bdll_pkg::REQ_REM_MID, '0);
    send_request(bdll_pkg::REQ_INS_FRONT, 32'h8000_0000);
    send_request(bdll_pkg::REQ_INS_BACK, 32'h7FFF_FFFF);
    send_request(bdll_pkg::REQ_INS_BACK, 32'hFFFF_FFFF);
    send_request(bdll_pkg::REQ_INS_FRONT, 32'd0);
    send_request(bdll_pkg::REQ_INS_BACK, 32'hFFFF_FFFF); // duplicate: head-most one goes
    send_request(bdll_pkg::REQ_REM_VALUE, 32'hFFFF_FFFF);
    send_request(bdll_pkg::REQ_REM_VALUE, 32'd12345);    // not found
    send_request(bdll_pkg::REQ_REM_MID, '0);
    send_request(REQ_SPARE6, 32'hA5A5_A5A5);
    send_request(REQ_SPARE7, 32'h5A5A_5A5A);
    send_request(bdll_pkg::REQ_REM_BACK, '0);
    send_request(bdll_pkg::REQ_REM_FRONT, '0);
    send_request(bdll_pkg::REQ_REM_MID, '0);
    send_request(bdll_pkg::REQ_REM_FRONT, '0);
    // Fill to capacity and beyond: pool full refusals.
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(($urandom_range(0, 1) != 0) ? bdll_pkg::REQ_INS_BACK
                                               : bdll_pkg::REQ_INS_FRONT, rand_value());
    send_request(bdll_pkg::REQ_REM_MID, '0);
    send_request(bdll_pkg::REQ_REM_VALUE, recent[$urandom_range(0, recent.size() - 1)]);

    // Pause until every expected reply has arrived.
    while (sb.pending.size() != 0) @(posedge clk);

    // Random: bursts with gaps; fill bias flips so list swings full and empty.
    fill_bias = 0;
    for (int n = 0; n < 800; ) begin
      if (n % 150 == 0) begin
        fill_bias = ~fill_bias;
        stall_mode = $urandom_range(0, 3);
      end
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        req = rand_req(fill_bias);
        v = rand_value();
        if (req == bdll_pkg::REQ_REM_VALUE && recent.size() != 0 && $urandom_range(0, 3) != 0)
          v = recent[$urandom_range(0, recent.size() - 1)];
        send_request(req, v);
        n++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 20));
    end

    stall_mode = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    finished = 1;
    $display("Checked %0d replies: %0d done, %0d empty, %0d not found, %0d full.",
             sb.checked, sb.status_seen[0], sb.status_seen[1],
             sb.status_seen[2], sb.status_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: ~900 requests, each bounded by a full-list search plus stalls and gaps.
  initial begin
    wait (cycles >= 400000);
    if (!finished) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
endmodule

[files.f]
+incdir+design
design/bdll_pkg.sv
design/bdll_ram.sv
design/bounded_doubly_linked_list_core.sv
tb/tb_top.sv
